### rtl/kie_pkg.sv
package kie_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;

    localparam logic [2:0] CMD_DIGIT = 3'd0;
    localparam logic [2:0] CMD_ADD   = 3'd1;
    localparam logic [2:0] CMD_SUB   = 3'd2;
    localparam logic [2:0] CMD_MUL   = 3'd3;
    localparam logic [2:0] CMD_DIV   = 3'd4;
    localparam logic [2:0] CMD_CLEAR = 3'd5;
    localparam logic [2:0] CMD_EVAL  = 3'd6;

    typedef enum logic [1:0] {
        TOP_NONE = 2'd0,
        TOP_MUL  = 2'd1,
        TOP_DIV  = 2'd2
    } term_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] digit;
    } key_item_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] value;
        logic                        div_by_zero;
    } res_item_t;

    typedef struct packed {
        logic start;
        logic div;
    } md_ctrl_t;

endpackage

### rtl/keypad_infix_evaluator_unit.sv
// keypad infix evaluator
// key channel: key_valid / key_stall carry one key item (command, digit).
// res channel: res_valid / res_stall carry one result item (value, div_by_zero),
// produced only for the evaluate command.
// multiply and divide bind tighter than add and subtract; each level runs left
// to right; arithmetic wraps at VALUE_WIDTH bits, division truncates toward zero.
// a digit, clear or unused command is handled in the idle state. an operator or
// evaluate with no pending multiply/divide goes to the apply state, as does an
// evaluate right after an operator. an operator, or an evaluate after a digit,
// with one pending first waits for the shared multiply/divide unit, which shifts
// one bit a cycle, so that unit sets the key rate.
// key_stall is high while a key is in work; the next key is taken once it ends.
// the result sits in an output register; a stalled result holds, and the key
// channel keeps accepting keys until a second evaluate needs that register.
// reset (rst_n low, asynchronous) clears the expression, the error flag and the
// output valid; a clear command returns the expression to the same state.
module keypad_infix_evaluator_unit #(
    parameter int VALUE_WIDTH = kie_pkg::VALUE_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               key_valid,
    output logic               key_stall,
    input  kie_pkg::key_item_t key,
    output logic               res_valid,
    input  logic               res_stall,
    output kie_pkg::res_item_t res
);

    localparam int W = VALUE_WIDTH;

    kie_pkg::state_t   state_reg, state_next;
    kie_pkg::term_op_t top_reg, top_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [W-1:0]      sum_reg, sum_next;
    logic              neg_reg, neg_next;
    logic [W-1:0]      prod_reg, prod_next;
    logic [W-1:0]      entry_reg, entry_next;
    logic              seen_reg, seen_next;
    logic              err_reg, err_next;
    logic [W-1:0]      term_reg, term_next;
    logic              res_valid_reg, res_valid_next;
    kie_pkg::res_item_t res_reg, res_next;

    kie_pkg::md_ctrl_t md_ctrl;
    logic              md_done;
    logic [W-1:0]      md_result;
    logic              md_dz;

    logic              accept;
    logic              top_md;
    logic [W-1:0]      signed_term;
    logic [W-1:0]      total;

    kie_muldiv #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (md_ctrl),
        .a      (prod_reg),
        .b      (entry_reg),
        .done   (md_done),
        .result (md_result),
        .dz     (md_dz)
    );

    assign key_stall   = (state_reg != kie_pkg::ST_IDLE);
    assign accept      = key_valid && !key_stall;
    assign top_md      = (top_reg == kie_pkg::TOP_MUL) || (top_reg == kie_pkg::TOP_DIV);
    assign signed_term = neg_reg ? (~term_reg + 1'b1) : term_reg;
    assign total       = sum_reg + signed_term;

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        cmd_next       = cmd_reg;
        sum_next       = sum_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        entry_next     = entry_reg;
        seen_next      = seen_reg;
        err_next       = err_reg;
        term_next      = term_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        md_ctrl.start  = 1'b0;
        md_ctrl.div    = (top_reg == kie_pkg::TOP_DIV);

        unique case (state_reg)
            kie_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = key.command;
                    unique case (key.command)
                        kie_pkg::CMD_DIGIT:
                        begin
                            entry_next = {entry_reg[W-4:0], 3'b000}
                                       + {entry_reg[W-2:0], 1'b0}
                                       + W'(key.digit);
                            seen_next  = 1'b1;
                        end
                        kie_pkg::CMD_ADD, kie_pkg::CMD_SUB,
                        kie_pkg::CMD_MUL, kie_pkg::CMD_DIV:
                        begin
                            if (top_md)
                            begin
                                md_ctrl.start = 1'b1;
                                state_next    = kie_pkg::ST_WAIT;
                            end
                            else
                            begin
                                term_next  = entry_reg;
                                state_next = kie_pkg::ST_APPLY;
                            end
                        end
                        kie_pkg::CMD_EVAL:
                        begin
                            if (seen_reg && top_md)
                            begin
                                md_ctrl.start = 1'b1;
                                state_next    = kie_pkg::ST_WAIT;
                            end
                            else
                            begin
                                // trailing operator is dropped
                                if (seen_reg)
                                begin
                                    term_next = entry_reg;
                                end
                                else if (top_md)
                                begin
                                    term_next = prod_reg;
                                end
                                else
                                begin
                                    term_next = '0;
                                end
                                state_next = kie_pkg::ST_APPLY;
                            end
                        end
                        kie_pkg::CMD_CLEAR:
                        begin
                            top_next   = kie_pkg::TOP_NONE;
                            sum_next   = '0;
                            neg_next   = 1'b0;
                            prod_next  = '0;
                            entry_next = '0;
                            seen_next  = 1'b0;
                            err_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            kie_pkg::ST_WAIT:
            begin
                if (md_done)
                begin
                    term_next  = md_result;
                    err_next   = err_reg | md_dz;
                    state_next = kie_pkg::ST_APPLY;
                end
            end
            kie_pkg::ST_APPLY:
            begin
                if (cmd_reg == kie_pkg::CMD_EVAL)
                begin
                    // wait for the output register to free up
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_next.value       = kie_pkg::OUT_WIDTH'($signed(total));
                        res_next.div_by_zero = err_reg;
                        res_valid_next       = 1'b1;
                        state_next           = kie_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    if (cmd_reg == kie_pkg::CMD_MUL || cmd_reg == kie_pkg::CMD_DIV)
                    begin
                        prod_next = term_reg;
                        top_next  = (cmd_reg == kie_pkg::CMD_MUL) ? kie_pkg::TOP_MUL
                                                                  : kie_pkg::TOP_DIV;
                    end
                    else
                    begin
                        sum_next  = total;
                        neg_next  = (cmd_reg == kie_pkg::CMD_SUB);
                        prod_next = '0;
                        top_next  = kie_pkg::TOP_NONE;
                    end
                    entry_next = '0;
                    seen_next  = 1'b0;
                    state_next = kie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kie_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kie_pkg::ST_IDLE;
            top_reg       <= kie_pkg::TOP_NONE;
            sum_reg       <= '0;
            neg_reg       <= 1'b0;
            prod_reg      <= '0;
            entry_reg     <= '0;
            seen_reg      <= 1'b0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            sum_reg       <= sum_next;
            neg_reg       <= neg_next;
            prod_reg      <= prod_next;
            entry_reg     <= entry_next;
            seen_reg      <= seen_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        term_reg <= term_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_start_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_ctrl.start |=> state_reg == kie_pkg::ST_WAIT)
        else $error("multiply/divide started without waiting for it");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> state_reg == kie_pkg::ST_WAIT)
        else $error("multiply/divide finished outside the wait state");

    a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg) == kie_pkg::ST_APPLY
                             && $past(cmd_reg) == kie_pkg::CMD_EVAL)
        else $error("result item not caused by an evaluate");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && key.command == kie_pkg::CMD_CLEAR
        |=> sum_reg == '0 && !err_reg && !seen_reg && top_reg == kie_pkg::TOP_NONE)
        else $error("clear left expression state behind");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(err_reg) |-> $past(accept) && $past(key.command) == kie_pkg::CMD_CLEAR)
        else $error("error flag dropped without a clear");

endmodule

### rtl/kie_muldiv.sv
module kie_muldiv #(
    parameter int VALUE_WIDTH = kie_pkg::VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  kie_pkg::md_ctrl_t      ctrl,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result,
    output logic                   dz
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          div_reg, div_next;
    logic          neg_reg, neg_next;
    logic          dz_reg, dz_next;
    // acc: product accumulator or partial remainder
    logic [W:0]    acc_reg, acc_next;
    // sa: multiplier or dividend/quotient; sb: multiplicand or divisor
    logic [W-1:0]  sa_reg, sa_next;
    logic [W-1:0]  sb_reg, sb_next;

    logic [W:0]    rem_shift;
    logic [W:0]    rem_diff;
    logic [W-1:0]  a_mag;
    logic [W-1:0]  b_mag;
    logic          last;

    assign a_mag     = a[W-1] ? (~a + 1'b1) : a;
    assign b_mag     = b[W-1] ? (~b + 1'b1) : b;
    assign rem_shift = {acc_reg[W-1:0], sa_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, sb_reg};
    assign last      = (cnt_reg == CW'(W - 1));

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        dz_next   = dz_reg;
        acc_next  = acc_reg;
        sa_next   = sa_reg;
        sb_next   = sb_reg;
        if (ctrl.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            div_next = ctrl.div;
            acc_next = '0;
            if (ctrl.div)
            begin
                neg_next = a[W-1] ^ b[W-1];
                dz_next  = (b == '0);
                sa_next  = a_mag;
                sb_next  = b_mag;
            end
            else
            begin
                neg_next = 1'b0;
                dz_next  = 1'b0;
                sa_next  = b;
                sb_next  = a;
            end
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (div_reg)
            begin
                // restoring step, one quotient bit per cycle
                if (!rem_diff[W])
                begin
                    acc_next = rem_diff;
                    sa_next  = {sa_reg[W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_shift;
                    sa_next  = {sa_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                if (sa_reg[0])
                begin
                    acc_next = {1'b0, acc_reg[W-1:0] + sb_reg};
                end
                sa_next = {1'b0, sa_reg[W-1:1]};
                sb_next = {sb_reg[W-2:0], 1'b0};
            end
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        dz_reg  <= dz_next;
        acc_reg <= acc_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
    end

    always_comb
    begin
        if (!div_reg)
        begin
            result = acc_reg[W-1:0];
        end
        else if (dz_reg)
        begin
            result = '0;
        end
        else if (neg_reg)
        begin
            result = ~sa_reg + 1'b1;
        end
        else
        begin
            result = sa_reg;
        end
    end

    assign done = done_reg;
    assign dz   = div_reg & dz_reg;

endmodule

### bench/keypad_infix_evaluator_unit_test.sv
`timescale 1ns / 1ps

module keypad_infix_evaluator_unit_test;
    import kie_pkg::*;

    localparam int VW           = VALUE_WIDTH;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_KEYS  = 1880;

    // the one command code the block ignores
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam logic [2:0] OPERATORS [4] = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};
    localparam longint unsigned EXTREMES [5] = '{
        64'd2147483647, 64'd2147483648, 64'd4294967295, 64'd4294967294, 64'd65536
    };

    typedef logic [VW-1:0] word_t;

    typedef enum logic [1:0] {
        STALL_NEVER,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_HEAVY
    } stall_style_t;

    logic      clk;
    logic      rst_n;
    logic      key_valid;
    logic      key_stall;
    key_item_t key;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    keypad_infix_evaluator_unit #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_valid(key_valid),
        .key_stall(key_stall),
        .key      (key),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // expression state of the predictor
    word_t     sum_so_far;
    logic      subtract_next;
    word_t     left_operand;
    term_op_t  pending_op;
    word_t     typed_number;
    logic      typed_any;
    logic      div_error;
    res_item_t expected_results[$];

    int           keys_sent        = 0;
    int           burst_left       = 0;
    bit           bursty_sender    = 1'b0;
    stall_style_t stall_style      = STALL_NEVER;
    int           hold_requests    = 0;
    int           holds_served     = 0;
    int           hold_left        = 0;
    logic [7:0]   stall_pattern    = 8'b0110_1001;
    int           pattern_age      = 0;
    int           failures         = 0;
    int           results_checked  = 0;
    int           div_zero_results = 0;
    int           cycle_count      = 0;
    res_item_t    oldest_expected;

    function automatic void clear_expression();
        sum_so_far    = '0;
        subtract_next = 1'b0;
        left_operand  = '0;
        pending_op    = TOP_NONE;
        typed_number  = '0;
        typed_any     = 1'b0;
        div_error     = 1'b0;
    endfunction

    // signed division toward zero on magnitudes; zero divisor gives zero and flags
    function automatic word_t truncated_quotient(word_t a, word_t b);
        word_t ma;
        word_t mb;
        word_t q;
        if (b == '0)
        begin
            div_error = 1'b1;
            return '0;
        end
        ma = a[VW-1] ? -a : a;
        mb = b[VW-1] ? -b : b;
        q  = ma / mb;
        return (a[VW-1] != b[VW-1]) ? -q : q;
    endfunction

    function automatic word_t closed_term();
        case (pending_op)
            TOP_MUL: return left_operand * typed_number;
            TOP_DIV: return truncated_quotient(left_operand, typed_number);
            default: return typed_number;
        endcase
    endfunction

    function automatic word_t signed_add(word_t acc, word_t t, logic negate);
        return negate ? acc - t : acc + t;
    endfunction

    function automatic void predict_key(key_item_t k);
        word_t     t;
        res_item_t r;
        case (k.command)
            CMD_DIGIT:
            begin
                typed_number = typed_number * word_t'(10) + word_t'(k.digit);
                typed_any    = 1'b1;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
            begin
                t = closed_term();
                if (k.command == CMD_MUL || k.command == CMD_DIV)
                begin
                    left_operand = t;
                    pending_op   = (k.command == CMD_MUL) ? TOP_MUL : TOP_DIV;
                end
                else
                begin
                    sum_so_far    = signed_add(sum_so_far, t, subtract_next);
                    subtract_next = (k.command == CMD_SUB);
                    left_operand  = '0;
                    pending_op    = TOP_NONE;
                end
                typed_number = '0;
                typed_any    = 1'b0;
            end
            CMD_CLEAR:
            begin
                clear_expression();
            end
            CMD_EVAL:
            begin
                // a trailing operator contributes nothing beyond its left operand
                if (typed_any)
                    t = closed_term();
                else if (pending_op == TOP_MUL || pending_op == TOP_DIV)
                    t = left_operand;
                else
                    t = '0;
                r.value       = OUT_WIDTH'(signed'(signed_add(sum_so_far, t, subtract_next)));
                r.div_by_zero = div_error;
                expected_results.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endfunction

    task automatic send_key(logic [2:0] command, logic [3:0] digit);
        key_item_t k;
        k.command = command;
        k.digit   = digit;
        if (bursty_sender)
        begin
            if (burst_left == 0)
            begin
                key_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        key_valid <= 1'b1;
        key       <= k;
        @(posedge clk);
        while (key_stall)
            @(posedge clk);
        predict_key(k);
        if (command != CMD_UNUSED)
            keys_sent++;
    endtask

    // non-digit keys carry a random, ignored digit field
    task automatic press(logic [2:0] command);
        send_key(command, 4'($urandom_range(0, 15)));
    endtask

    task automatic type_value(longint unsigned n);
        logic [3:0] digits [20];
        int         count;
        count = 0;
        do
        begin
            digits[5'(count)] = 4'(n % 10);
            n = n / 10;
            count++;
        end
        while (n != 0);
        for (int i = count - 1; i >= 0; i--)
            send_key(CMD_DIGIT, digits[5'(i)]);
    endtask

    task automatic type_random_operand();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // empty operand
        end
        else if (pick < 18)
            send_key(CMD_DIGIT, 4'd0);
        else if (pick < 55)
            type_value(64'($urandom_range(1, 99)));
        else if (pick < 75)
            type_value(64'($urandom_range(100, 999999)));
        else if (pick < 90)
            type_value(EXTREMES[3'($urandom_range(0, 4))]);
        else
        begin
            // long raw entry, digits above nine included, wraps
            repeat ($urandom_range(8, 12))
                send_key(CMD_DIGIT, 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic random_expression();
        if ($urandom_range(0, 9) < 7)
            press(CMD_CLEAR);
        repeat ($urandom_range(0, 5))
        begin
            type_random_operand();
            press(OPERATORS[2'($urandom_range(0, 3))]);
        end
        type_random_operand();
        if ($urandom_range(0, 6) == 0)
            press(OPERATORS[2'($urandom_range(0, 3))]);
        repeat ($urandom_range(1, 3))
            press(CMD_EVAL);
    endtask

    task automatic noise_keys();
        repeat ($urandom_range(1, 8))
            send_key(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
        press(CMD_EVAL);
    endtask

    // most negative value divided by minus one
    task automatic wrap_division();
        press(CMD_CLEAR);
        if ($urandom_range(0, 1) == 1)
            type_value(64'd2147483648);
        else
        begin
            type_value(64'd65536);
            press(CMD_MUL);
            type_value(64'd32768);
        end
        press(CMD_DIV);
        type_value(64'd4294967295);
        press(CMD_EVAL);
    endtask

    // the sender goes idle until every expected result has come out
    task automatic wait_results_drained();
        key_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_special_keys();
        bursty_sender = 1'b0;
        stall_style   = STALL_RANDOM;
        press(CMD_EVAL);
        send_key(CMD_DIGIT, 4'd9);
        send_key(CMD_DIGIT, 4'd15);
        press(CMD_MUL);
        send_key(CMD_DIGIT, 4'd7);
        send_key(CMD_UNUSED, 4'hA);
        press(CMD_EVAL);
        press(CMD_SUB);
        send_key(CMD_DIGIT, 4'd8);
        press(CMD_DIV);
        send_key(CMD_DIGIT, 4'd0);
        press(CMD_EVAL);
        press(CMD_ADD);
        press(CMD_EVAL);
        send_key(CMD_DIGIT, 4'd3);
        press(CMD_DIV);
        press(CMD_EVAL);
        press(CMD_CLEAR);
        press(CMD_EVAL);
        press(CMD_SUB);
        send_key(CMD_DIGIT, 4'd2);
        press(CMD_EVAL);
    endtask

    task automatic test_back_pressure();
        bursty_sender = 1'b0;
        hold_requests++;
        key_valid <= 1'b0;
        @(posedge clk);
        while (!res_stall)
            @(posedge clk);
        // evaluates pile up behind the held output until the key side stalls
        repeat (6)
        begin
            send_key(CMD_DIGIT, 4'($urandom_range(0, 9)));
            press(CMD_EVAL);
        end
    endtask

    task automatic test_drain_pause();
        bursty_sender = 1'b1;
        stall_style   = STALL_PATTERN;
        random_expression();
        wait_results_drained();
        random_expression();
    endtask

    task automatic test_random();
        int target;
        int pick;
        target = keys_sent + RANDOM_KEYS;
        while (keys_sent < target)
        begin
            bursty_sender = ($urandom_range(0, 4) != 0);
            stall_style   = stall_style_t'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 82)
                random_expression();
            else if (pick < 95)
                noise_keys();
            else
                wrap_division();
        end
    endtask

    // receiver stall pattern, long holds counted here
    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            res_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            case (stall_style)
                STALL_RANDOM:  res_stall <= ($urandom_range(0, 99) < 35);
                STALL_PATTERN: res_stall <= stall_pattern[3'(pattern_age % 8)];
                STALL_HEAVY:   res_stall <= ($urandom_range(0, 99) < 85);
                default:       res_stall <= 1'b0;
            endcase
        end
        pattern_age++;
        if (pattern_age == 64)
        begin
            pattern_age   = 0;
            stall_pattern = 8'($urandom);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
                note_failure($sformatf("unexpected result value %0d flag %0b",
                                       res.value, res.div_by_zero));
            else
            begin
                oldest_expected = expected_results.pop_front();
                results_checked++;
                if (oldest_expected.div_by_zero)
                    div_zero_results++;
                if (res.value !== oldest_expected.value)
                    note_failure($sformatf("value expected %0d got %0d",
                                           oldest_expected.value, res.value));
                if (res.div_by_zero !== oldest_expected.div_by_zero)
                    note_failure($sformatf("div_by_zero expected %0b got %0b",
                                           oldest_expected.div_by_zero, res.div_by_zero));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("keypad_infix_evaluator_unit_test: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        key_valid = 1'b0;
        key       = '0;
        clear_expression();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_special_keys();
        test_back_pressure();
        test_drain_pause();
        test_random();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results (%0d with the divide-by-zero flag) from %0d keys",
                 results_checked, div_zero_results, keys_sent);
        $display("bursty keys, stalled results, %0d long output holds, %0d mismatches",
                 holds_served, failures);
        if (failures == 0)
            $display("keypad_infix_evaluator_unit_test: clean");
        else
            $display("keypad_infix_evaluator_unit_test: errors");
        $finish;
    end

endmodule

### keypad_infix_evaluator_unit.f
rtl/kie_pkg.sv
rtl/kie_muldiv.sv
rtl/keypad_infix_evaluator_unit.sv
bench/keypad_infix_evaluator_unit_test.sv
